// ===== rtl/sorted_list_insert_remove_defines.svh =====
// Assertion macros shared by the checker of the sorted list block.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef SORTED_LIST_INSERT_REMOVE_DEFINES_SVH
`define SORTED_LIST_INSERT_REMOVE_DEFINES_SVH

// Implication in the same cycle.
`define SLRI_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted list check failed");

// Implication in the following cycle.
`define SLRI_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted list check failed");

`endif

// ===== rtl/slri_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package slri_pkg;

	// Request codes.
	localparam logic FUNC_ADD    = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	// Status codes.
	localparam logic [1:0] ST_ADDED     = 2'd0;
	localparam logic [1:0] ST_REMOVED   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic               func;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [6:0] count;
	} rsp_t;

	// Control broadcast from the sequencer to every cell of the row.
	typedef struct packed {
		logic load; // capture the compare flags against the new word
		logic add;  // shift right from the insert point and write the word
		logic rem;  // shift left over the matching entry
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/slri_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module slri_cell #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  slri_pkg::cell_ctl_t   ctl,
	input  logic [DATA_WIDTH-1:0] val,
	input  logic                  valid,
	input  logic                  left_ge,
	input  logic [DATA_WIDTH-1:0] left_entry,
	input  logic [DATA_WIDTH-1:0] right_entry,
	output logic [DATA_WIDTH-1:0] entry,
	output logic                  ge,
	output logic                  hit
);
	import slri_pkg::*;

	logic [DATA_WIDTH-1:0] entry_q;
	logic                  ge_q;
	logic                  eq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ge_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.load) begin
			ge_q <= valid & ($signed(entry_q) >= $signed(val));
			eq_q <= (entry_q == val);
		end
	end

	// The list is ascending, so the cells that compare greater or equal form a
	// suffix of the valid cells, and the insert or remove point is its head.
	always_ff @(posedge clk) begin
		if (ctl.add) begin
			if (left_ge) begin
				entry_q <= left_entry;
			end else if (ge_q || !valid) begin
				entry_q <= val;
			end
		end else if (ctl.rem && ge_q) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;
	assign ge    = ge_q;
	assign hit   = ge_q & eq_q & ~left_ge;

endmodule

`default_nettype wire

// ===== rtl/sorted_list_insert_remove.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted word enters the update state, then its result is strobed on done.
// No word is taken while busy is high for the update cycle of the cell row.
// Each word has the compare cycle followed by the shift cycle of the cell row.
// Reset (arst_n low) empties the list and clears the sequencer; no clearing pass runs.
// The receiver cannot stall: each result is shown for exactly one cycle.

module sorted_list_insert_remove #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  slri_pkg::req_t req,
	output logic           done,
	output slri_pkg::rsp_t rsp
);
	import slri_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	// Sequencer states: waiting for a word, or applying the shift in the cells.
	localparam logic S_IDLE = 1'b0;
	localparam logic S_UPD  = 1'b1;

	logic                  state_q;
	logic [CW-1:0]         count_q;
	logic                  func_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic                  done_q;
	rsp_t                  rsp_q;

	logic                  accept;
	logic                  full;
	logic                  found;
	logic [DATA_WIDTH+31:0] val_ext;
	logic [DATA_WIDTH-1:0] val_d;
	logic [DATA_WIDTH-1:0] val_bus;
	logic [CW-1:0]         count_next;
	logic [1:0]            status_next;
	logic [CW+6:0]         count_ext;
	cell_ctl_t             ctl;

	logic [DATA_WIDTH-1:0] entry_arr [CAPACITY];
	logic [CAPACITY-1:0]   ge_vec;
	logic [CAPACITY-1:0]   hit_vec;
	logic [CAPACITY-1:0]   valid_vec;

	assign accept = start & ~busy;
	assign busy   = (state_q == S_UPD);

	// Only the low DATA_WIDTH bits of the word's value count; wider lists see it
	// zero extended.
	assign val_ext = {{DATA_WIDTH{1'b0}}, req.value};
	assign val_d   = val_ext[DATA_WIDTH-1:0];

	// The cells compare against the incoming word while idle and write the
	// captured word during the update cycle.
	assign val_bus = (state_q == S_IDLE) ? val_d : val_q;

	assign full  = (count_q == CW'(CAPACITY));
	// At most one cell sits at the head of the greater-or-equal run and matches.
	assign found = |hit_vec;

	always_comb begin
		ctl.load = accept;
		ctl.add  = busy & (func_q == FUNC_ADD) & ~full;
		ctl.rem  = busy & (func_q == FUNC_REMOVE) & found;
	end

	always_comb begin
		count_next  = count_q;
		status_next = ST_NOT_FOUND;
		if (func_q == FUNC_ADD) begin
			if (full) begin
				status_next = ST_FULL;
			end else begin
				status_next = ST_ADDED;
				count_next  = count_q + CW'(1);
			end
		end else if (found) begin
			status_next = ST_REMOVED;
			count_next  = count_q - CW'(1);
		end
	end

	// The count field is seven bits wide whatever the capacity.
	assign count_ext = {7'b0, count_next};

	// The row of cells. Each cell hands its entry to both neighbors and its
	// compare flag to the right one.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                  left_ge;
		logic [DATA_WIDTH-1:0] left_entry;
		logic [DATA_WIDTH-1:0] right_entry;

		assign valid_vec[i] = (count_q > CW'(i));

		if (i == 0) begin : g_first
			assign left_ge    = 1'b0;
			assign left_entry = val_bus;
		end else begin : g_inner
			assign left_ge    = ge_vec[i-1];
			assign left_entry = entry_arr[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = entry_arr[i];
		end else begin : g_body
			assign right_entry = entry_arr[i+1];
		end

		slri_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.val        (val_bus),
			.valid      (valid_vec[i]),
			.left_ge    (left_ge),
			.left_entry (left_entry),
			.right_entry(right_entry),
			.entry      (entry_arr[i]),
			.ge         (ge_vec[i]),
			.hit        (hit_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					count_q <= count_next;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Captured word and result word carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
			val_q  <= val_d;
		end
		if (busy) begin
			rsp_q.status <= status_next;
			rsp_q.count  <= count_ext[6:0];
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/slri_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_list_insert_remove_defines.svh"

module slri_chk (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire slri_pkg::req_t req,
	input wire logic           done,
	input wire slri_pkg::rsp_t rsp
);
	import slri_pkg::*;

	logic req_seen;
	assign req_seen = req.func | ~req.func;

	// An accepted word yields its result on done after the update phase.
	`SLRI_ASSERT_IMP(a_result_follows, start && !busy && req_seen, ##2 done)
	// The update phase lasts a single cycle.
	`SLRI_ASSERT_NXT(a_busy_one_cycle, busy, !busy)
	// A result is only shown right after the update phase.
	`SLRI_ASSERT_IMP(a_done_after_busy, done, $past(busy) && !busy)
	// A successful add never reports an empty list.
	`SLRI_ASSERT_IMP(a_added_nonempty, done && (rsp.status == ST_ADDED), rsp.count != 7'd0)

endmodule

bind sorted_list_insert_remove slri_chk u_chk (.*);

`default_nettype wire

// ===== tb/sv/tb_sorted_list_insert_remove.sv =====
`timescale 1ns / 1ps

module tb_sorted_list_insert_remove;
	import slri_pkg::*;

	localparam int LIST_DEPTH = 64;
	localparam int VALUE_BITS = 32;
	// Cycles with neither an accepted word nor a strobed result before the run is abandoned.
	localparam int STALL_LIMIT = 1000;
	// Cycles to keep watching once nothing is expected, to catch stray results.
	localparam int DRAIN_CYCLES = 6;

	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t rsp;

	// Shadow copy of the list contents, kept in ascending order like the block's cell row.
	logic signed [31:0] list_shadow[$];
	// Responses predicted for accepted words, oldest first.
	rsp_t pending_rsp[$];

	int error_count = 0;
	int quiet_cycles = 0;
	// When cleared, the sender keeps start high between words to push back-to-back.
	bit gaps_on = 1'b1;

	sorted_list_insert_remove #(
		.CAPACITY(LIST_DEPTH),
		.DATA_WIDTH(VALUE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// Applies one request to the shadow list and returns the response the block should give.
	// An add goes in front of the first entry that is greater than or equal to the value,
	// so it lands ahead of any equal entries. A remove drops the lowest equal entry.
	function automatic rsp_t apply_list_request(req_t r);
		rsp_t res;
		int pos;
		logic signed [31:0] v;
		v = r.value;
		res = '0;
		if (r.func == FUNC_ADD) begin
			if (list_shadow.size() >= LIST_DEPTH) begin
				res.status = ST_FULL;
			end else begin
				pos = list_shadow.size();
				for (int i = 0; i < list_shadow.size(); i++) begin
					if (list_shadow[i] >= v) begin
						pos = i;
						break;
					end
				end
				list_shadow.insert(pos, v);
				res.status = ST_ADDED;
			end
		end else begin
			res.status = ST_NOT_FOUND;
			for (int i = 0; i < list_shadow.size(); i++) begin
				if (list_shadow[i] == v) begin
					list_shadow.delete(i);
					res.status = ST_REMOVED;
					break;
				end
			end
		end
		res.count = 7'(list_shadow.size());
		return res;
	endfunction

	// Drives one word and holds it until the block takes it. The response is predicted
	// at the accepting edge. Afterwards the sender may go quiet; when it does not, start simply
	// stays high and the next call loads the next word in the same
	// step, so start never gets two assignments at one edge.
	task automatic send_word(input logic f, input logic signed [31:0] v);
		req_t r;
		r.func = f;
		r.value = v;
		start <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (!(start && !busy));
		pending_rsp.push_back(apply_list_request(r));
		if (gaps_on && $urandom_range(99) < 33) begin
			start <= 1'b0;
			req <= req_t'({$urandom, $urandom});
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Value mix: a narrow pool so that duplicates and hits on remove are common, the
	// extremes of the signed range, and full random words so every bit toggles.
	function automatic logic signed [31:0] pick_value();
		int sel;
		sel = $urandom_range(99);
		if (sel < 40)
			return 32'($signed($urandom_range(8)) - 4);
		else if (sel < 55) begin
			case ($urandom_range(3))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return 32'sd0;
				default: return -32'sd1;
			endcase
		end else
			return $signed($urandom);
	endfunction

	// Picks a value for a remove: mostly one that is stored, so entries actually leave.
	function automatic logic signed [31:0] pick_remove_value(int hit_pct);
		if (list_shadow.size() != 0 && $urandom_range(99) < hit_pct)
			return list_shadow[$urandom_range(list_shadow.size() - 1)];
		return pick_value();
	endfunction

	// Holds the sender off until every predicted response has come back.
	task automatic wait_all_done();
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	// Extremes, removes on an empty list, duplicate handling and misses.
	task automatic test_directed();
		send_word(FUNC_REMOVE, 32'sd0);
		send_word(FUNC_ADD, 32'sd0);
		send_word(FUNC_ADD, VAL_MIN);
		send_word(FUNC_ADD, VAL_MAX);
		send_word(FUNC_ADD, -32'sd1);
		send_word(FUNC_ADD, 32'sd1);
		send_word(FUNC_ADD, 32'sd5);
		send_word(FUNC_ADD, 32'sd5);
		send_word(FUNC_ADD, -32'sd5);
		send_word(FUNC_ADD, 32'shAAAA_AAAA);
		send_word(FUNC_ADD, 32'sh5555_5555);
		send_word(FUNC_REMOVE, 32'sd5);
		send_word(FUNC_REMOVE, 32'sd5);
		send_word(FUNC_REMOVE, 32'sd5);
		send_word(FUNC_REMOVE, VAL_MAX);
		send_word(FUNC_REMOVE, 32'sd7);
		send_word(FUNC_REMOVE, 32'shAAAA_AAAA);
		send_word(FUNC_REMOVE, 32'sh5555_5555);
		send_word(FUNC_REMOVE, -32'sd1);
		send_word(FUNC_REMOVE, 32'sd0);
		send_word(FUNC_REMOVE, 32'sd1);
		send_word(FUNC_REMOVE, -32'sd5);
		send_word(FUNC_REMOVE, VAL_MIN);
		send_word(FUNC_REMOVE, VAL_MIN);
	endtask

	// Fills the list to capacity, knocks on it while full, then empties it again.
	// A few removes that miss and adds that refill are mixed into the drain.
	task automatic test_fill_and_drain(input int rounds);
		int sel;
		for (int k = 0; k < rounds; k++) begin
			while (list_shadow.size() < LIST_DEPTH) begin
				if ($urandom_range(99) < 10)
					send_word(FUNC_REMOVE, pick_remove_value(30));
				else
					send_word(FUNC_ADD, pick_value());
			end
			repeat ($urandom_range(2, 4)) send_word(FUNC_ADD, pick_value());
			send_word(FUNC_REMOVE, $signed($urandom));
			send_word(FUNC_ADD, VAL_MIN);
			while (list_shadow.size() != 0) begin
				sel = $urandom_range(99);
				if (sel < 80)
					send_word(FUNC_REMOVE, pick_remove_value(100));
				else if (sel < 92)
					send_word(FUNC_REMOVE, pick_value());
				else
					send_word(FUNC_ADD, pick_value());
			end
			send_word(FUNC_REMOVE, pick_value());
		end
	endtask

	// Free mix of adds and removes around the middle of the list.
	task automatic test_random_mix(input int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(1))
				send_word(FUNC_ADD, pick_value());
			else
				send_word(FUNC_REMOVE, pick_remove_value(60));
		end
	endtask

	// Same mix with the sender never pausing, so words arrive as fast as busy allows.
	task automatic test_back_to_back(input int n);
		gaps_on = 1'b0;
		test_random_mix(n);
		gaps_on = 1'b1;
	endtask

	// Lets the list drain of responses in the middle of traffic, then carries on.
	task automatic test_pause_and_resume(input int n);
		test_random_mix(n);
		wait_all_done();
		repeat ($urandom_range(2, 6)) @(posedge clk);
		test_random_mix(n);
	endtask

	// Each result is checked at the falling edge of the cycle it is strobed in, so the
	// compare never shares a time step with the sender's push of a new prediction.
	always @(negedge clk) begin
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected result: status %0d count %0d", rsp.status, rsp.count);
				error_count++;
			end else begin
				if (rsp.status !== pending_rsp[0].status) begin
					$error("status: expected %0d, got %0d", pending_rsp[0].status, rsp.status);
					error_count++;
				end
				if (rsp.count !== pending_rsp[0].count) begin
					$error("count: expected %0d, got %0d", pending_rsp[0].count, rsp.count);
					error_count++;
				end
				void'(pending_rsp.pop_front());
			end
		end
	end

	// The watchdog restarts whenever a word is taken or a result comes out.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("** sorted_list_insert_remove: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_and_drain(2);
		test_random_mix(400);
		test_back_to_back(250);
		test_pause_and_resume(150);
		test_fill_and_drain(2);
		test_random_mix(150);

		wait_all_done();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_rsp.size() == 0)
			$display("** sorted_list_insert_remove: PASSED **");
		else
			$display("** sorted_list_insert_remove: FAILED **");
		$finish;
	end

endmodule

// ===== sorted_list_insert_remove.f =====
+incdir+rtl
rtl/slri_pkg.sv
rtl/slri_cell.sv
rtl/sorted_list_insert_remove.sv
rtl/slri_chk.sv
tb/sv/tb_sorted_list_insert_remove.sv
